// ===== rtl/pf_pkg.sv =====
// Playfair digraph encipher: shared types, letter and action codes, helpers.
// No dependencies; used by pf_locate and playfair_digraph_encipher.
package pf_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] pos_t;
  typedef logic [1:0] action_t;
  typedef logic [1:0] reg_index_t;

  localparam int unsigned SIDE = 5;

  typedef letter_t [SIDE-1:0][SIDE-1:0] grid_t;

  localparam letter_t LETTER_X   = 5'd23;
  localparam letter_t LETTER_Q   = 5'd16;
  localparam letter_t LETTER_MAX = 5'd25;
  localparam letter_t LETTER_NONE = 5'd0;

  localparam action_t ACT_LETTER    = 2'd0;
  localparam action_t ACT_LINE_END  = 2'd1;
  localparam action_t ACT_END_INPUT = 2'd2;

  localparam logic KIND_DIGRAPH = 1'b0;
  localparam logic KIND_BREAK   = 1'b1;

  localparam reg_index_t REG_ROWS_0_1 = 2'd0;
  localparam reg_index_t REG_ROWS_2_3 = 2'd1;
  localparam reg_index_t REG_ROW_4    = 2'd2;

  localparam pos_t POS_LAST = 3'(SIDE - 1);

  // Digraph waiting for encipher, plus a pending line break.
  typedef struct packed {
    logic    pair_v;
    letter_t a;
    letter_t b;
    logic    brk;
  } work_t;

  // Square position of a letter.
  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } loc_t;

  function automatic pos_t wrap_next(input pos_t p);
    return (p == POS_LAST) ? 3'd0 : p + 3'd1;
  endfunction

endpackage

// ===== rtl/pf_locate.sv =====
// Finds the lowest square cell holding a letter code.
// Depends on pf_pkg (grid_t, loc_t).
module pf_locate (
  input  pf_pkg::grid_t   grid,
  input  pf_pkg::letter_t code,
  output pf_pkg::loc_t    loc
);

  always_comb begin
    loc = '0;
    // scan high to low so the lowest match wins
    for (int r = pf_pkg::SIDE - 1; r >= 0; r--) begin
      for (int c = pf_pkg::SIDE - 1; c >= 0; c--) begin
        if (grid[3'(r)][3'(c)] == code) begin
          loc.found = 1'b1;
          loc.row   = 3'(r);
          loc.col   = 3'(c);
        end
      end
    end
  end

endmodule

// ===== rtl/playfair_digraph_encipher.sv =====
// Playfair digraph encipher top level: pairing into an input register, then
// locate and substitution into the result register. Depends on pf_pkg and pf_locate.
//
// Takes one character word per cycle (letter, line end, end of input) and
// returns enciphered digraphs and line breaks over a single result port. A word
// is accepted every cycle the result port keeps up; a line end that closes a
// pending letter yields two results and holds the result port until both are
// taken, so the sustained rate is set by that port. The first result of a word
// passes through the input register, then the result register, before it is
// presented. The user must load the key square through the cfg port only while
// the block is idle; the block does not enforce this. The square resets to zero.
module playfair_digraph_encipher (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  pf_pkg::action_t     action,
  input  pf_pkg::letter_t     letter,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                kind,
  output pf_pkg::letter_t     first_out,
  output pf_pkg::letter_t     second_out,
  output logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  pf_pkg::reg_index_t  cfg_index,
  input  logic [49:0]         cfg_data
);

  logic [49:0] square_rows_0_1;
  logic [49:0] square_rows_2_3;
  logic [24:0] square_row_4;
  pf_pkg::grid_t grid;

  logic            held_valid, held_valid_next;
  pf_pkg::letter_t held_letter, held_letter_next;
  pf_pkg::work_t   work_next;
  pf_pkg::letter_t in_letter;

  logic          s1_valid;
  pf_pkg::work_t s1;
  pf_pkg::loc_t  loc0, loc1;

  logic            out_pair_v, out_brk_v;
  pf_pkg::letter_t out_a, out_b;
  pf_pkg::letter_t enc_a, enc_b;

  logic accept, out_done, out_free, out_load, s1_free, s1_load;

  // config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_rows_0_1 <= '0;
      square_rows_2_3 <= '0;
      square_row_4    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pf_pkg::REG_ROWS_0_1: square_rows_0_1 <= cfg_data;
        pf_pkg::REG_ROWS_2_3: square_rows_2_3 <= cfg_data;
        pf_pkg::REG_ROW_4:    square_row_4    <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // cell n sits at bits 5n of the packed grid
  assign grid = {square_row_4, square_rows_2_3, square_rows_0_1};

  // handshake chain
  assign out_done = result_valid && !result_stall && !(out_pair_v && out_brk_v);
  assign out_free = !result_valid || out_done;
  assign out_load = s1_valid && out_free;
  assign s1_free  = !s1_valid || out_load;
  assign item_stall = !s1_free;
  assign accept   = item_valid && !item_stall;

  // pairing
  assign in_letter = (letter == pf_pkg::LETTER_Q) ? pf_pkg::LETTER_X : letter;

  always_comb begin
    held_valid_next  = held_valid;
    held_letter_next = held_letter;
    work_next        = '0;
    work_next.a      = held_letter;
    work_next.b      = pf_pkg::LETTER_X;
    unique case (action)
      pf_pkg::ACT_LETTER: begin
        if (letter <= pf_pkg::LETTER_MAX) begin
          if (!held_valid) begin
            held_valid_next  = 1'b1;
            held_letter_next = in_letter;
          end else if (in_letter == held_letter && in_letter != pf_pkg::LETTER_X) begin
            work_next.pair_v = 1'b1;
          end else begin
            work_next.pair_v = 1'b1;
            work_next.b      = in_letter;
            held_valid_next  = 1'b0;
          end
        end
      end
      pf_pkg::ACT_LINE_END: begin
        work_next.pair_v = held_valid;
        work_next.brk    = 1'b1;
        held_valid_next  = 1'b0;
      end
      pf_pkg::ACT_END_INPUT: begin
        work_next.pair_v = held_valid;
        held_valid_next  = 1'b0;
      end
      default: ;
    endcase
  end

  assign s1_load = accept && (work_next.pair_v || work_next.brk);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      held_letter <= '0;
    end else if (accept) begin
      held_valid  <= held_valid_next;
      held_letter <= held_letter_next;
    end
  end

  // input register: paired digraph
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= work_next;
    end
  end

  pf_locate u_locate_a (
    .grid (grid),
    .code (s1.a),
    .loc  (loc0)
  );

  pf_locate u_locate_b (
    .grid (grid),
    .code (s1.b),
    .loc  (loc1)
  );

  // substitution
  always_comb begin
    pf_pkg::pos_t nr0, nc0, nr1, nc1;
    nr0 = loc0.row;
    nc0 = loc0.col;
    nr1 = loc1.row;
    nc1 = loc1.col;
    if (loc0.col == loc1.col) begin
      nr0 = pf_pkg::wrap_next(loc0.row);
      nr1 = pf_pkg::wrap_next(loc1.row);
    end else if (loc0.row == loc1.row) begin
      nc0 = pf_pkg::wrap_next(loc0.col);
      nc1 = pf_pkg::wrap_next(loc1.col);
    end else begin
      nc0 = loc1.col;
      nc1 = loc0.col;
    end
    if (!loc0.found || !loc1.found ||
        (loc0.row == loc1.row && loc0.col == loc1.col)) begin
      enc_a = s1.a;
      enc_b = s1.b;
    end else begin
      enc_a = grid[nr0][nc0];
      enc_b = grid[nr1][nc1];
    end
  end

  // result register: digraph first, then line break
  always_ff @(posedge clk) begin
    if (rst) begin
      out_pair_v <= 1'b0;
      out_brk_v  <= 1'b0;
    end else if (out_load) begin
      out_pair_v <= s1.pair_v;
      out_brk_v  <= s1.brk;
    end else if (result_valid && !result_stall) begin
      priority if (out_pair_v) begin
        out_pair_v <= 1'b0;
      end else begin
        out_brk_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_a <= enc_a;
      out_b <= enc_b;
    end
  end

  assign result_valid = out_pair_v || out_brk_v;
  assign kind         = out_pair_v ? pf_pkg::KIND_DIGRAPH : pf_pkg::KIND_BREAK;
  assign first_out    = out_pair_v ? out_a : pf_pkg::LETTER_NONE;
  assign second_out   = out_pair_v ? out_b : pf_pkg::LETTER_NONE;
  assign last         = !(out_pair_v && out_brk_v);

  // checks
  a_break_follows_pair: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && out_pair_v && out_brk_v
      |=> result_valid && kind == pf_pkg::KIND_BREAK && last)
    else $error("line break lost after digraph");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid)
    else $error("input stalled with free pipeline slot");

  a_held_letter_legal: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> held_letter <= pf_pkg::LETTER_MAX && held_letter != pf_pkg::LETTER_Q)
    else $error("illegal held letter");

endmodule

// ===== tb/sv/playfair_digraph_encipher_tb.sv =====
// Self-checking testbench for playfair_digraph_encipher: directed and random character
// streams under several key squares, predicted in-bench and checked word by word.
// Depends on pf_pkg and the playfair_digraph_encipher RTL.
module playfair_digraph_encipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned PHASE_CHARS = 255;
  localparam int unsigned NO_CELL = 25;
  localparam pf_pkg::reg_index_t REG_SPARE = 2'd3;
  localparam pf_pkg::action_t ACT_SPARE = 2'd3;

  typedef enum {SQ_PLAIN, SQ_SHUFFLED, SQ_ZERO, SQ_ONES, SQ_PATCHY} sq_style_t;

  typedef struct packed {
    pf_pkg::action_t act;
    pf_pkg::letter_t ltr;
  } char_t;

  typedef struct packed {
    logic            kind;
    pf_pkg::letter_t fo;
    pf_pkg::letter_t so;
    logic            last;
  } cipher_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  pf_pkg::action_t    action = pf_pkg::ACT_LETTER;
  pf_pkg::letter_t    letter = 5'd0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               kind;
  pf_pkg::letter_t    first_out;
  pf_pkg::letter_t    second_out;
  logic               last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  pf_pkg::reg_index_t cfg_index = pf_pkg::REG_ROWS_0_1;
  logic [49:0]        cfg_data = '0;

  playfair_digraph_encipher uut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .action(action),
    .letter(letter),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .first_out(first_out),
    .second_out(second_out),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // in-bench copy of the key square and pairing state
  logic [49:0]     sq01 = '0;
  logic [49:0]     sq23 = '0;
  logic [24:0]     sq4 = '0;
  logic            held_v = 1'b0;
  pf_pkg::letter_t held_l = 5'd0;

  char_t   pending_chars[$];
  cipher_t due_cipher[$];

  int unsigned send_pct = 21;
  int unsigned recv_pct = 49;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  logic        squeeze = 1'b0;
  logic        squeezed = 1'b0;
  int unsigned hold_left = 0;
  char_t       next_char;
  cipher_t     want;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pf_pkg::letter_t sq_cell(int unsigned n);
    if (n < 10) return sq01[5*n +: 5];
    if (n < 20) return sq23[5*(n-10) +: 5];
    return sq4[5*(n-20) +: 5];
  endfunction

  function automatic int unsigned sq_find(pf_pkg::letter_t code);
    for (int unsigned n = 0; n < NO_CELL; n++)
      if (sq_cell(n) == code) return n;
    return NO_CELL;
  endfunction

  function automatic void pair_cipher(input pf_pkg::letter_t a, input pf_pkg::letter_t b,
                                      output pf_pkg::letter_t oa,
                                      output pf_pkg::letter_t ob);
    int unsigned i0, i1;
    i0 = sq_find(a);
    i1 = sq_find(b);
    oa = a;
    ob = b;
    if (i0 < NO_CELL && i1 < NO_CELL && i0 != i1) begin
      if (i0 % 5 == i1 % 5) begin
        oa = sq_cell((i0 + 5) % NO_CELL);
        ob = sq_cell((i1 + 5) % NO_CELL);
      end else if (i0 / 5 == i1 / 5) begin
        oa = sq_cell(i0 / 5 * 5 + (i0 % 5 + 1) % 5);
        ob = sq_cell(i1 / 5 * 5 + (i1 % 5 + 1) % 5);
      end else begin
        oa = sq_cell(i0 / 5 * 5 + i1 % 5);
        ob = sq_cell(i1 / 5 * 5 + i0 % 5);
      end
    end
  endfunction

  // advance pairing state by one accepted word, queue the cipher output it owes
  function automatic void cipher_step(pf_pkg::action_t act, pf_pkg::letter_t ltr);
    pf_pkg::letter_t a, b, c;
    c = (ltr == pf_pkg::LETTER_Q) ? pf_pkg::LETTER_X : ltr;
    case (act)
      pf_pkg::ACT_LETTER: begin
        if (ltr <= pf_pkg::LETTER_MAX) begin
          if (!held_v) begin
            held_l = c;
            held_v = 1'b1;
          end else if (c == held_l && c != pf_pkg::LETTER_X) begin
            pair_cipher(held_l, pf_pkg::LETTER_X, a, b);
            due_cipher.push_back({pf_pkg::KIND_DIGRAPH, a, b, 1'b1});
          end else begin
            pair_cipher(held_l, c, a, b);
            due_cipher.push_back({pf_pkg::KIND_DIGRAPH, a, b, 1'b1});
            held_v = 1'b0;
          end
        end
      end
      pf_pkg::ACT_LINE_END: begin
        if (held_v) begin
          pair_cipher(held_l, pf_pkg::LETTER_X, a, b);
          due_cipher.push_back({pf_pkg::KIND_DIGRAPH, a, b, 1'b0});
          held_v = 1'b0;
        end
        due_cipher.push_back({pf_pkg::KIND_BREAK, pf_pkg::LETTER_NONE,
                              pf_pkg::LETTER_NONE, 1'b1});
      end
      pf_pkg::ACT_END_INPUT: begin
        if (held_v) begin
          pair_cipher(held_l, pf_pkg::LETTER_X, a, b);
          due_cipher.push_back({pf_pkg::KIND_DIGRAPH, a, b, 1'b1});
          held_v = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [124:0] make_square(sq_style_t style);
    logic [124:0]    cells;
    pf_pkg::letter_t perm[25];
    pf_pkg::letter_t t;
    int unsigned     k, j;
    cells = '0;
    k = 0;
    for (int unsigned l = 0; l <= pf_pkg::LETTER_MAX; l++) begin
      if (l != pf_pkg::LETTER_Q) begin
        perm[k] = 5'(l);
        k++;
      end
    end
    if (style != SQ_PLAIN) begin
      for (int i = 24; i > 0; i--) begin
        j = $urandom_range(i);
        t = perm[i];
        perm[i] = perm[j];
        perm[j] = t;
      end
    end
    for (int unsigned n = 0; n < NO_CELL; n++)
      cells[5*n +: 5] = perm[n];
    if (style == SQ_PATCHY) begin
      repeat (6) cells[5*$urandom_range(24) +: 5] = 5'($urandom_range(31));
    end
    if (style == SQ_ZERO) cells = '0;
    if (style == SQ_ONES) cells = '1;
    return cells;
  endfunction

  task automatic cfg_write(pf_pkg::reg_index_t idx, logic [49:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      pf_pkg::REG_ROWS_0_1: sq01 = val;
      pf_pkg::REG_ROWS_2_3: sq23 = val;
      pf_pkg::REG_ROW_4:    sq4 = val[24:0];
      default: ;
    endcase
  endtask

  task automatic load_square(sq_style_t style);
    logic [124:0] cells;
    cells = make_square(style);
    cfg_write(pf_pkg::REG_ROWS_0_1, cells[49:0]);
    cfg_write(pf_pkg::REG_ROWS_2_3, cells[99:50]);
    cfg_write(pf_pkg::REG_ROW_4, {25'($urandom), cells[124:100]});
    @(negedge clk);
  endtask

  task automatic push_char(pf_pkg::action_t act, pf_pkg::letter_t ltr);
    pending_chars.push_back({act, ltr});
  endtask

  // mostly plain text with repeats, line ends and a little noise
  task automatic fill_random(int unsigned count);
    int unsigned     made, r;
    pf_pkg::letter_t prev;
    made = 0;
    prev = 5'd0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 6) begin
        push_char(pf_pkg::ACT_LINE_END, 5'($urandom));
        made++;
      end else if (r < 9) begin
        push_char(pf_pkg::ACT_END_INPUT, 5'($urandom));
        made++;
      end else if (r < 12) begin
        push_char(pf_pkg::ACT_LETTER, 5'($urandom_range(31, 26)));
      end else if (r < 14) begin
        push_char(ACT_SPARE, 5'($urandom));
      end else begin
        if ($urandom_range(9) != 0) prev = 5'($urandom_range(25));
        push_char(pf_pkg::ACT_LETTER, prev);
        made++;
      end
    end
  endtask

  task automatic settle();
    while (pending_chars.size() != 0 || item_valid || due_cipher.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) cipher_step(action, letter);
      if (!item_valid || !item_stall) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_pct) begin
          next_char = pending_chars.pop_front();
          item_valid <= 1'b1;
          action <= next_char.act;
          letter <= next_char.ltr;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (due_cipher.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: kind=%0d first=%0d second=%0d last=%0d",
                     kind, first_out, second_out, last);
        end else begin
          want = due_cipher.pop_front();
          if (kind !== want.kind || first_out !== want.fo ||
              second_out !== want.so || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp kind=%0d first=%0d second=%0d last=%0d, got %0d %0d %0d %0d",
                       want.kind, want.fo, want.so, want.last,
                       kind, first_out, second_out, last);
          end
        end
      end
      if (squeeze && !squeezed) begin
        hold_left = HOLD_CYCLES;
        squeezed = 1'b1;
      end
      result_stall <= (hold_left > 0) || ($urandom_range(99) < recv_pct);
      if (hold_left > 0) hold_left--;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sq_style_t plan[6];
    plan = '{SQ_SHUFFLED, SQ_ZERO, SQ_PATCHY, SQ_ONES, SQ_SHUFFLED, SQ_PATCHY};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    load_square(SQ_PLAIN);
    push_char(pf_pkg::ACT_LETTER, 5'd0);   // a b: same row
    push_char(pf_pkg::ACT_LETTER, 5'd1);
    push_char(pf_pkg::ACT_LETTER, 5'd4);   // e a: row wrap
    push_char(pf_pkg::ACT_LETTER, 5'd0);
    push_char(pf_pkg::ACT_LETTER, 5'd0);   // a v: column wrap
    push_char(pf_pkg::ACT_LETTER, 5'd21);
    push_char(pf_pkg::ACT_LETTER, 5'd1);   // b z: rectangle
    push_char(pf_pkg::ACT_LETTER, 5'd25);
    push_char(pf_pkg::ACT_LETTER, pf_pkg::LETTER_Q);
    push_char(pf_pkg::ACT_LETTER, 5'd10);
    push_char(pf_pkg::ACT_LETTER, 5'd11);  // l l m: double letter
    push_char(pf_pkg::ACT_LETTER, 5'd11);
    push_char(pf_pkg::ACT_LETTER, 5'd12);
    push_char(pf_pkg::ACT_LETTER, pf_pkg::LETTER_X);
    push_char(pf_pkg::ACT_LETTER, pf_pkg::LETTER_X);
    push_char(pf_pkg::ACT_LETTER, 5'd2);
    push_char(pf_pkg::ACT_LINE_END, 5'd0);
    push_char(pf_pkg::ACT_LINE_END, 5'd31);
    push_char(pf_pkg::ACT_LETTER, 5'd3);
    push_char(pf_pkg::ACT_END_INPUT, 5'd0);
    push_char(pf_pkg::ACT_END_INPUT, 5'd0);
    push_char(pf_pkg::ACT_LETTER, 5'd26);  // out of range, dropped
    push_char(pf_pkg::ACT_LETTER, 5'd31);
    push_char(ACT_SPARE, 5'd31);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_pct = 49;
        recv_pct = 21;
      end
      if (ph == 4) begin
        send_pct = 0;
        recv_pct = 0;
      end
      load_square(plan[ph]);
      if (ph == 1) cfg_write(REG_SPARE, {18'($urandom), 32'($urandom)});
      if (ph == 4) squeeze = 1'b1;
      fill_random(PHASE_CHARS);
      settle();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pf_pkg.sv
rtl/pf_locate.sv
rtl/playfair_digraph_encipher.sv
tb/sv/playfair_digraph_encipher_tb.sv
